>>> rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and types for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // Decimal digit cells: 2147483648 has ten digits
    localparam int NUM_DIGITS = 10;
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W      = $clog2(VALUE_W);

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Control for the row of digit cells
    typedef struct packed {
        logic clear;   // set digit to zero
        logic dabble;  // add-3 correction, then shift one bit in
        logic move;    // take the neighbour's digit (towards the top)
    } cell_ctrl_t;

endpackage

>>> rtl/sitoa_if.sv
// ----------------------------------------------------------------------------
// sitoa_if
// Valid/ready channels for the number request and the text character.
// ----------------------------------------------------------------------------
interface sitoa_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
// The number channel takes one signed 32-bit value per request. The text
// channel returns its decimal characters, most significant first, one per
// request: a leading '-' for negative values, no leading zeros, and a
// single '0' for zero. The final character of each number has last set.
// The magnitude is shifted one bit per cycle through a row of ten BCD
// cells (double dabble). Leading zero digits are then dropped at one
// per cycle by moving the row towards the top cell, after which
// characters leave at one per cycle while the receiver is not stalled.
// One number is handled at a time. A stalled receiver holds the output
// register and the row simply waits. The next number is taken while the
// final character still waits in the output register. Reset empties the
// output register and returns the unit to idle; the working and digit
// registers have no reset.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
    input  logic               clk,
    input  logic               rst_n,
    sitoa_in_if.sink           number,
    sitoa_out_if.source        text
);
    import sitoa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_DIGS = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    cell_ctrl_t         cell_ctrl;
    logic               accept;
    logic               slot_free;
    logic [DIGIT_W-1:0] digit_w [NUM_DIGITS];
    logic               carry_w [NUM_DIGITS];
    logic [DIGIT_W-1:0] top_digit;
    logic               rem_one;

    assign accept    = number.valid && number.ready;
    assign slot_free = !out_valid_reg || text.ready;
    assign top_digit = digit_w[NUM_DIGITS-1];
    assign rem_one   = (rem_reg == REM_W'(1));
    assign carry_w[0] = mag_reg[VALUE_W-1];

    // Row of digit cells, least significant digit in cell 0.
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        logic [DIGIT_W-1:0] nb_digit;

        if (i == 0)
        begin : g_first
            assign nb_digit = '0;
        end
        else
        begin : g_rest
            assign nb_digit = digit_w[i-1];
        end

        if (i < NUM_DIGITS - 1)
        begin : g_carry
            sitoa_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .carry_in  (carry_w[i]),
                .digit_in  (nb_digit),
                .carry_out (carry_w[i+1]),
                .digit     (digit_w[i])
            );
        end
        else
        begin : g_top
            sitoa_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .carry_in  (carry_w[i]),
                .digit_in  (nb_digit),
                .carry_out (),
                .digit     (digit_w[i])
            );
        end
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        cell_ctrl      = '0;
        number.ready   = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next        = number.value[VALUE_W-1];
                    mag_next        = number.value[VALUE_W-1]
                                      ? (~number.value + VALUE_W'(1))
                                      : number.value;
                    cnt_next        = '0;
                    rem_next        = REM_W'(NUM_DIGITS);
                    cell_ctrl.clear = 1'b1;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.dabble = 1'b1;
                mag_next         = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next         = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit != '0) || rem_one)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGS;
                end
                else
                begin
                    cell_ctrl.move = 1'b1;
                    rem_next       = rem_reg - REM_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGS;
                end
            end
            ST_DIGS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    out_last_next  = rem_one;
                    cell_ctrl.move = 1'b1;
                    rem_next       = rem_reg - REM_W'(1);
                    if (rem_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign text.valid    = out_valid_reg;
    assign text.out_char = out_char_reg;
    assign text.last     = out_last_reg;

endmodule

>>> rtl/sitoa_cell.sv
// ----------------------------------------------------------------------------
// sitoa_cell
// One BCD digit of the conversion row: double-dabble step or digit move.
// ----------------------------------------------------------------------------
module sitoa_cell (
    input  logic                          clk,
    input  sitoa_pkg::cell_ctrl_t         ctrl,
    input  logic                          carry_in,
    input  logic [sitoa_pkg::DIGIT_W-1:0] digit_in,
    output logic                          carry_out,
    output logic [sitoa_pkg::DIGIT_W-1:0] digit
);
    import sitoa_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add three when the digit would overflow past nine after doubling.
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    // Next digit value.
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    // Digit storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

>>> rtl/sitoa_checker.sv
// ----------------------------------------------------------------------------
// sitoa_checker
// Port-level checks on the integer to decimal text unit, bound to the top.
// ----------------------------------------------------------------------------
module sitoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);
    import sitoa_pkg::*;

    // A waiting character holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
        else $error("text request changed while stalled");

    // Only the minus sign and decimal digits are ever produced.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == CHAR_MINUS) ||
                      ((out_char >= CHAR_ZERO) && (out_char <= CHAR_ZERO + 8'd9)))
        else $error("character outside the expected set");

    // The sign never ends a number.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == CHAR_MINUS) |-> !out_last)
        else $error("minus sign marked as last");

    // The unit is busy in the first and the last cycle of the bit-serial conversion.
    a_busy_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##31 !in_ready)
        else $error("number taken during conversion");

endmodule

bind signed_int_to_decimal_ascii_unit sitoa_checker u_sitoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.out_char),
    .out_last  (text.last)
);
